// File: hw/rtl/mdh16_pkg.sv
package mdh16_pkg;

	localparam int unsigned NumRounds = 16;
	localparam int unsigned NumWords  = 6;

	typedef logic [15:0] word_t;

	// identifier words travel packed, word 0 in the low slot
	typedef logic [NumWords-1:0][15:0] msg_t;

	// working registers of the mixing function
	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
	} hstate_t;

	// boolean function of a round group
	typedef enum logic [1:0] {
		FUNC_SEL_F = 2'd0,
		FUNC_MIX_G = 2'd1,
		FUNC_XOR_H = 2'd2,
		FUNC_ORN_I = 2'd3
	} func_t;

	// everything that tells one round apart from another
	typedef struct packed {
		word_t       k;
		logic [3:0]  rot;
		logic [2:0]  sel;
		func_t       func;
	} round_cfg_t;

	localparam hstate_t InitState = '{a: 16'h2301, b: 16'hab89, c: 16'hdcfe, d: 16'h5476};

	localparam word_t RoundK [NumRounds] = '{
		16'ha478, 16'h0faf, 16'h98d8, 16'h1122,
		16'h2562, 16'h105d, 16'hcde6, 16'he905,
		16'h3942, 16'hea44, 16'h7ec6, 16'hd039,
		16'h2244, 16'h59c3, 16'h7e4f, 16'h7e82
	};

	localparam logic [3:0] RoundRot [NumRounds] = '{
		4'd7, 4'd12, 4'd1, 4'd6,
		4'd5, 4'd9, 4'd14, 4'd2,
		4'd4, 4'd11, 4'd0, 4'd3,
		4'd8, 4'd10, 4'd15, 4'd13
	};

	// message word picked by each round
	localparam logic [2:0] RoundSel [NumRounds] = '{
		3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
		3'd1, 3'd0,
		3'd5, 3'd2, 3'd5, 3'd2,
		3'd0, 3'd2, 3'd4, 3'd0
	};

	function automatic round_cfg_t round_cfg(input logic [3:0] idx);
		round_cfg_t cfg;
		cfg.k   = RoundK[idx];
		cfg.rot = RoundRot[idx];
		cfg.sel = RoundSel[idx];
		if (idx < 4'd6) begin
			cfg.func = FUNC_SEL_F;
		end else if (idx < 4'd8) begin
			cfg.func = FUNC_MIX_G;
		end else if (idx < 4'd12) begin
			cfg.func = FUNC_XOR_H;
		end else begin
			cfg.func = FUNC_ORN_I;
		end
		return cfg;
	endfunction

endpackage

// File: hw/rtl/md5_style_id_hash16.sv
// 16-bit MD5-style identifier hash: six 16-bit identifier words in,
// four 16-bit hash words out, one result beat per input beat.
// Input channel: in_valid/in_ready with uid_word_0..uid_word_5.
// Output channel: out_valid/out_ready with hash_word_a..hash_word_d.
// The datapath is a row of 16 round cells, one round per cell, each cell
// registered; the last cell's register is the output register.
// Throughput: one beat per cycle while the output side keeps taking beats.
// Each cell advances whenever it is empty or its neighbor takes its beat, so
// bubbles close up and input is still taken while a finished result waits,
// until all 16 cells hold beats.
// When the receiver stalls, results hold steady on the output ports and the
// row fills; in_ready drops once every cell is occupied.
// Reset clears all cell valid flags: the block comes out of reset empty,
// with out_valid low and in_ready high.
module md5_style_id_hash16 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] uid_word_0,
	input  logic [15:0] uid_word_1,
	input  logic [15:0] uid_word_2,
	input  logic [15:0] uid_word_3,
	input  logic [15:0] uid_word_4,
	input  logic [15:0] uid_word_5,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] hash_word_a,
	output logic [15:0] hash_word_b,
	output logic [15:0] hash_word_c,
	output logic [15:0] hash_word_d
);
	import mdh16_pkg::*;

	logic    valid [NumRounds+1];
	logic    ready [NumRounds+1];
	hstate_t state [NumRounds+1];
	msg_t    msg   [NumRounds+1];

	// chain head
	assign valid[0] = in_valid;
	assign in_ready = ready[0];
	assign state[0] = InitState;
	assign msg[0]   = {uid_word_5, uid_word_4, uid_word_3, uid_word_2, uid_word_1, uid_word_0};

	// one cell per round
	for (genvar i = 0; i < NumRounds; i++) begin : g_round
		mdh16_round_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cfg      (round_cfg(4'(i))),
			.up_valid (valid[i]),
			.up_ready (ready[i]),
			.up_state (state[i]),
			.up_msg   (msg[i]),
			.dn_valid (valid[i+1]),
			.dn_ready (ready[i+1]),
			.dn_state (state[i+1]),
			.dn_msg   (msg[i+1])
		);
	end

	// chain tail drives the output beat; message words end here
	assign ready[NumRounds] = out_ready;
	assign out_valid        = valid[NumRounds] && (msg[NumRounds] == msg[NumRounds]);
	assign hash_word_a      = state[NumRounds].a;
	assign hash_word_b      = state[NumRounds].b;
	assign hash_word_c      = state[NumRounds].c;
	assign hash_word_d      = state[NumRounds].d;

endmodule

// File: hw/rtl/mdh16_round_cell.sv
module mdh16_round_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mdh16_pkg::round_cfg_t   cfg,
	input  logic                    up_valid,
	output logic                    up_ready,
	input  mdh16_pkg::hstate_t      up_state,
	input  mdh16_pkg::msg_t         up_msg,
	output logic                    dn_valid,
	input  logic                    dn_ready,
	output mdh16_pkg::hstate_t      dn_state,
	output mdh16_pkg::msg_t         dn_msg
);
	import mdh16_pkg::*;

	logic    valid_q;
	hstate_t state_q;
	msg_t    msg_q;
	word_t   f;
	word_t   sum;
	word_t   rotd;
	logic [31:0] dbl;
	hstate_t next_state;

	// round boolean function
	always_comb begin
		case (cfg.func)
			FUNC_SEL_F: f = (up_state.b & up_state.c) | (~up_state.b & up_state.d);
			FUNC_MIX_G: f = (up_state.b & up_state.d) | (up_state.c & ~up_state.d);
			FUNC_XOR_H: f = up_state.b ^ up_state.c ^ up_state.d;
			FUNC_ORN_I: f = up_state.c ^ (up_state.b | ~up_state.d);
			default:    f = '0;
		endcase
	end

	// add, rotate left, add b; a shift of 16 on the doubled word covers zero rotation
	always_comb begin
		sum  = f + up_state.a + cfg.k + up_msg[cfg.sel];
		dbl  = {sum, sum} >> (5'd16 - {1'b0, cfg.rot});
		rotd = dbl[15:0];
		next_state.a = up_state.d;
		next_state.d = up_state.c;
		next_state.c = up_state.b;
		next_state.b = up_state.b + rotd;
	end

	// stage moves when empty or when the next one takes its beat
	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			state_q <= next_state;
			msg_q   <= up_msg;
		end
	end

	assign dn_valid = valid_q;
	assign dn_state = state_q;
	assign dn_msg   = msg_q;

endmodule
